FILE: design/crcfr_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame receiver.
`timescale 1ns / 1ps

package crcfr_pkg;

  localparam int BUFFER_DEPTH_DEF = 32;

  localparam logic [7:0]  HDR_FIRST  = 8'h55;
  localparam logic [7:0]  HDR_SECOND = 8'hAA;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID_HIGH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID_LOW  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_LEN_ERR = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_HUNT,
    S_HDR2,
    S_LEN,
    S_IDH,
    S_IDL,
    S_CMD,
    S_DATA,
    S_CRC,
    S_REP_RD,
    S_REP_OUT
  } state_t;

  typedef struct packed {
    logic    load_len;
    logic    store;
    logic    take_crc_hi;
    logic    rep_start;
    logic    rep_next;
    logic    emit;
    status_t emit_status;
  } cmd_t;

  typedef struct packed {
    logic hdr1_hit;
    logic hdr2_hit;
    logic len_too_big;
    logic id_hi_ok;
    logic id_lo_ok;
    logic store_full;
    logic crc_ok;
    logic len_zero;
    logic rep_last;
    logic out_free;
  } sts_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: design/crcfr_if.sv
// Channel interfaces: received bytes, result beats and configuration writes.
`timescale 1ns / 1ps

interface crcfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crcfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [1:0] status;
  logic       last;
  modport source (output valid, output payload_byte, output status, output last, input ready);
  modport sink (input valid, input payload_byte, input status, input last, output ready);
endinterface

interface crcfr_cfg_if import crcfr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/crc16_frame_receiver.sv
// Top level of the CRC-16 frame receiver: parser control, datapath and channel wiring.
// Order: an error beat is valid the cycle after the byte that causes it; the first
// replayed beat follows the CRC low byte via replay index, store read and result registers.
// Throughput: one received byte per cycle while no result beat waits; a good frame replays
// a beat per read and output state; input is held until replay ends and while a beat waits.
// Reset: synchronous active-low rst_n; parser hunts for the header, IDs read zero.
`timescale 1ns / 1ps

module crc16_frame_receiver import crcfr_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  crcfr_in_if.sink   in_ch,
  crcfr_out_if.source out_ch,
  crcfr_cfg_if.sink  cfg_ch
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  crcfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  crcfr_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .rx_byte          (in_ch.rx_byte),
    .cfg_we           (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_payload_byte (out_ch.payload_byte),
    .out_status       (out_ch.status),
    .out_last         (out_ch.last)
  );

endmodule

FILE: design/crcfr_ctrl.sv
// Frame parser state machine: issues datapath commands and the input handshake.
`timescale 1ns / 1ps

module crcfr_ctrl import crcfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_ready = (state_r != S_REP_RD) && (state_r != S_REP_OUT) && sts.out_free;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_HUNT: if (in_fire) state_nxt = sts.hdr1_hit ? S_HDR2 : S_HUNT;
      S_HDR2: if (in_fire) state_nxt = sts.hdr2_hit ? S_LEN : S_HUNT;
      S_LEN:  if (in_fire) state_nxt = sts.len_too_big ? S_HUNT : S_IDH;
      S_IDH:  if (in_fire) state_nxt = sts.id_hi_ok ? S_IDL : S_HUNT;
      S_IDL:  if (in_fire) state_nxt = sts.id_lo_ok ? S_CMD : S_HUNT;
      S_CMD:  if (in_fire) state_nxt = S_DATA;
      S_DATA: if (in_fire && sts.store_full) state_nxt = S_CRC;
      S_CRC: begin
        if (in_fire) begin
          state_nxt = (sts.crc_ok && !sts.len_zero) ? S_REP_RD : S_HUNT;
        end
      end
      S_REP_RD: state_nxt = S_REP_OUT;
      S_REP_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.rep_last ? S_HUNT : S_REP_RD;
        end
      end
      default: state_nxt = S_HUNT;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.emit_status = ST_DATA;
    unique case (state_r)
      S_LEN: begin
        if (in_fire) begin
          if (sts.len_too_big) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_LEN_ERR;
          end else begin
            cmd.load_len = 1'b1;
          end
        end
      end
      S_IDH: cmd.store = in_fire && sts.id_hi_ok;
      S_IDL: cmd.store = in_fire && sts.id_lo_ok;
      S_CMD: cmd.store = in_fire;
      S_DATA: begin
        cmd.store       = in_fire && !sts.store_full;
        cmd.take_crc_hi = in_fire && sts.store_full;
      end
      S_CRC: begin
        if (in_fire) begin
          if (sts.crc_ok) begin
            cmd.rep_start = !sts.len_zero;
          end else begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_CRC_ERR;
          end
        end
      end
      S_REP_OUT: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.rep_next = 1'b1;
        end
      end
      default: cmd.emit_status = ST_DATA;
    endcase
  end

endmodule

FILE: design/crcfr_dp.sv
// Frame datapath: ID registers, length and count, CRC, frame store, result register.
`timescale 1ns / 1ps

module crcfr_dp import crcfr_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           rx_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [7:0]           out_payload_byte,
  output logic [1:0]           out_status,
  output logic                 out_last
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  logic [7:0]    dev_id_hi_r, dev_id_lo_r;
  logic [AW-1:0] len_r, len_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    crc_hi_r;
  logic [AW-1:0] rep_idx_r, rep_idx_nxt;
  logic [7:0]    mem [BUFFER_DEPTH];
  logic [7:0]    mem_q_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r;
  logic [1:0]    out_status_r;
  logic          out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_id_hi_r <= 8'h00;
      dev_id_lo_r <= 8'h00;
    end else if (cfg_we) begin
      if (cfg_index == REG_DEVICE_ID_HIGH) dev_id_hi_r <= cfg_data;
      if (cfg_index == REG_DEVICE_ID_LOW)  dev_id_lo_r <= cfg_data;
    end
  end

  assign sts.hdr1_hit    = (rx_byte == HDR_FIRST);
  assign sts.hdr2_hit    = (rx_byte == HDR_SECOND);
  assign sts.len_too_big = (rx_byte > 8'(BUFFER_DEPTH - 1));
  assign sts.id_hi_ok    = (rx_byte == dev_id_hi_r);
  assign sts.id_lo_ok    = (rx_byte == dev_id_lo_r);
  assign sts.store_full  = (cnt_r > CW'(len_r));
  assign sts.crc_ok      = ({crc_hi_r, rx_byte} == crc_r);
  assign sts.len_zero    = (len_r == '0);
  assign sts.rep_last    = (rep_idx_r == len_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  always_comb begin
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    crc_nxt     = crc_r;
    rep_idx_nxt = rep_idx_r;
    mem_we      = 1'b0;
    mem_waddr   = cnt_r[AW-1:0];
    if (cmd.load_len) begin
      len_nxt   = rx_byte[AW-1:0];
      cnt_nxt   = CW'(1);
      crc_nxt   = crc16_byte(CRC_INIT, rx_byte);
      mem_we    = 1'b1;
      mem_waddr = '0;
    end else if (cmd.store) begin
      mem_we = (cnt_r < CW'(BUFFER_DEPTH));
      if (cnt_r <= CW'(len_r)) crc_nxt = crc16_byte(crc_r, rx_byte);
      if (cnt_r < CW'(BUFFER_DEPTH)) cnt_nxt = cnt_r + CW'(1);
    end
    if (cmd.rep_start) begin
      rep_idx_nxt = AW'(1);
    end else if (cmd.rep_next) begin
      rep_idx_nxt = rep_idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      cnt_r     <= '0;
      crc_r     <= CRC_INIT;
      crc_hi_r  <= 8'h00;
      rep_idx_r <= '0;
    end else begin
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      crc_r     <= crc_nxt;
      rep_idx_r <= rep_idx_nxt;
      if (cmd.take_crc_hi) crc_hi_r <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= rx_byte;
    mem_q_r <= mem[rep_idx_r];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      if (cmd.emit_status == ST_DATA) begin
        out_byte_r <= mem_q_r;
        out_last_r <= sts.rep_last;
      end else begin
        out_byte_r <= 8'h00;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

endmodule

FILE: dv/crc16_frame_receiver_checker.sv
// Checker for the frame receiver: tracks the parser, predicts result beats, compares them.
`timescale 1ns / 1ps

module crc16_frame_receiver_checker import crcfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [7:0]           out_payload_byte,
  input  logic [1:0]           out_status,
  input  logic                 out_last,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   mismatches,
  output int                   beats_waiting,
  output int                   beats_checked
);

  typedef enum logic [2:0] {
    PS_HUNT,
    PS_HDR2,
    PS_LEN,
    PS_ID_HI,
    PS_ID_LO,
    PS_CMD,
    PS_BODY,
    PS_CRC_LO
  } frame_step_t;

  typedef struct packed {
    logic [7:0] payload;
    status_t    status;
    logic       last;
  } result_beat_t;

  frame_step_t  frame_step;
  logic [7:0]   id_hi;
  logic [7:0]   id_lo;
  logic [7:0]   frame_len;
  logic [7:0]   stored_cnt;
  logic [7:0]   crc_hi_byte;
  logic [15:0]  crc_acc;
  logic [7:0]   frame_buf [BUFFER_DEPTH_DEF];
  result_beat_t expected_beats[$];

  function automatic logic [15:0] crc16_modbus_next(input logic [15:0] crc,
                                                    input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task absorb_frame_byte(input logic [7:0] b);
    if (stored_cnt < BUFFER_DEPTH_DEF) frame_buf[stored_cnt] = b;
    if (stored_cnt <= frame_len) crc_acc = crc16_modbus_next(crc_acc, b);
    if (stored_cnt != 8'hFF) stored_cnt = stored_cnt + 8'd1;
  endtask

  task predict_rx_byte(input logic [7:0] b);
    result_beat_t beat;
    case (frame_step)
      PS_HDR2: begin
        frame_step = (b == HDR_SECOND) ? PS_LEN : PS_HUNT;
      end
      PS_LEN: begin
        if (b > BUFFER_DEPTH_DEF - 1) begin
          beat = '{payload: 8'h00, status: ST_LEN_ERR, last: 1'b1};
          expected_beats.push_back(beat);
          frame_step = PS_HUNT;
        end else begin
          frame_len = b;
          stored_cnt = 8'd0;
          crc_acc = CRC_INIT;
          absorb_frame_byte(b);
          frame_step = PS_ID_HI;
        end
      end
      PS_ID_HI: begin
        if (b == id_hi) begin
          absorb_frame_byte(b);
          frame_step = PS_ID_LO;
        end else begin
          frame_step = PS_HUNT;
        end
      end
      PS_ID_LO: begin
        if (b == id_lo) begin
          absorb_frame_byte(b);
          frame_step = PS_CMD;
        end else begin
          frame_step = PS_HUNT;
        end
      end
      PS_CMD: begin
        absorb_frame_byte(b);
        frame_step = PS_BODY;
      end
      PS_BODY: begin
        if (9'(stored_cnt) < 9'(frame_len) + 9'd1) begin
          absorb_frame_byte(b);
        end else begin
          crc_hi_byte = b;
          frame_step = PS_CRC_LO;
        end
      end
      PS_CRC_LO: begin
        if ({crc_hi_byte, b} == crc_acc) begin
          for (int k = 1; k <= frame_len && k < BUFFER_DEPTH_DEF; k++) begin
            beat = '{payload: frame_buf[k], status: ST_DATA, last: (k == frame_len)};
            expected_beats.push_back(beat);
          end
        end else begin
          beat = '{payload: 8'h00, status: ST_CRC_ERR, last: 1'b1};
          expected_beats.push_back(beat);
        end
        frame_step = PS_HUNT;
      end
      default: begin
        frame_step = (b == HDR_FIRST) ? PS_HDR2 : PS_HUNT;
      end
    endcase
  endtask

  task report_beat(input string what, input bit have_exp, input result_beat_t exp);
    mismatches++;
    if (mismatches <= 10) begin
      if (have_exp) begin
        $display("[%0t] %s: expected payload %02h status %0d last %0d, got payload %02h status %0d last %0d",
                 $time, what, exp.payload, exp.status, exp.last,
                 out_payload_byte, out_status, out_last);
      end else begin
        $display("[%0t] %s: got payload %02h status %0d last %0d",
                 $time, what, out_payload_byte, out_status, out_last);
      end
    end
  endtask

  always @(posedge clk) begin
    result_beat_t exp;
    if (!rst_n) begin
      frame_step = PS_HUNT;
      id_hi = 8'h00;
      id_lo = 8'h00;
      frame_len = 8'h00;
      stored_cnt = 8'h00;
      crc_hi_byte = 8'h00;
      crc_acc = CRC_INIT;
      expected_beats.delete();
      mismatches = 0;
      beats_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEVICE_ID_HIGH: id_hi = cfg_data;
          REG_DEVICE_ID_LOW:  id_lo = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_rx_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        beats_checked++;
        if (expected_beats.size() == 0) begin
          report_beat("result beat with nothing outstanding", 1'b0, '0);
        end else begin
          exp = expected_beats.pop_front();
          if (out_payload_byte !== exp.payload || out_status !== exp.status ||
              out_last !== exp.last) begin
            report_beat("result beat mismatch", 1'b1, exp);
          end
        end
      end
    end
    beats_waiting = expected_beats.size();
  end

endmodule

FILE: dv/crc16_frame_receiver_tb.sv
// Testbench top for the frame receiver: clock, reset, frame stimulus, back-pressure, verdict.
`timescale 1ns / 1ps

module crc16_frame_receiver_tb;
  import crcfr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_TOP   = '1;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASE_BYTES     = 24;

  typedef enum {
    FR_GOOD,
    FR_BAD_CRC,
    FR_BAD_ID_HI,
    FR_BAD_ID_LO,
    FR_BAD_HDR2,
    FR_TOO_LONG,
    FR_CUT
  } frame_kind_t;

  logic clk;
  logic rst_n;

  crcfr_in_if  in_ch();
  crcfr_out_if out_ch();
  crcfr_cfg_if cfg_ch();

  int mismatches;
  int beats_waiting;
  int beats_checked;

  logic [7:0] dev_hi;
  logic [7:0] dev_lo;
  int bytes_sent;
  int frame_bytes;
  int frames_sent;
  int id_settings;
  int burst_left;
  bit hold_req;
  int hold_left;
  int stall_pct;
  int stall_span;

  crc16_frame_receiver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  crc16_frame_receiver_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_rx_byte       (in_ch.rx_byte),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_payload_byte (out_ch.payload_byte),
    .out_status       (out_ch.status),
    .out_last         (out_ch.last),
    .cfg_valid        (cfg_ch.valid),
    .cfg_ready        (cfg_ch.ready),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .mismatches       (mismatches),
    .beats_waiting    (beats_waiting),
    .beats_checked    (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d result beats outstanding", beats_waiting);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stall pattern in spans, plus a long hold-off on request
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_span = $urandom_range(20, 120);
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2: stall_pct = 30;
        3: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    stall_span--;
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_kind_t kind, input int len);
    logic [7:0] stored[$];
    logic [7:0] stream[$];
    logic [15:0] crc;
    logic [7:0] b;
    int n_send;
    stored = {};
    stored.push_back(len[7:0]);
    stored.push_back(kind == FR_BAD_ID_HI ? dev_hi ^ 8'($urandom_range(1, 255)) : dev_hi);
    stored.push_back(kind == FR_BAD_ID_LO ? dev_lo ^ 8'($urandom_range(1, 255)) : dev_lo);
    stored.push_back(8'($urandom));
    while (stored.size() < len + 1) stored.push_back(8'($urandom));
    crc = CRC_INIT;
    for (int i = 0; i <= len && i < stored.size(); i++) crc = crc16_next(crc, stored[i]);
    if (kind == FR_BAD_CRC) crc ^= 16'(1) << $urandom_range(0, 15);
    stream = {HDR_FIRST, HDR_SECOND};
    if (kind == FR_BAD_HDR2) begin
      do b = 8'($urandom); while (b == HDR_SECOND);
      stream[1] = b;
    end
    stream = {stream, stored, crc[15:8], crc[7:0]};
    case (kind)
      FR_BAD_HDR2:  n_send = 2;
      FR_TOO_LONG:  n_send = 3;
      FR_BAD_ID_HI: n_send = 4;
      FR_BAD_ID_LO: n_send = 5;
      FR_CUT:       n_send = $urandom_range(3, stream.size() - 1);
      default:      n_send = stream.size();
    endcase
    for (int i = 0; i < n_send; i++) send_byte(stream[i]);
    frames_sent++;
    frame_bytes += n_send;
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (beats_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_DEVICE_ID_HIGH) dev_hi = value;
    if (idx == REG_DEVICE_ID_LOW) dev_lo = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_ids(input logic [7:0] hi, input logic [7:0] lo);
    write_cfg(REG_DEVICE_ID_HIGH, hi);
    write_cfg(REG_DEVICE_ID_LOW, lo);
    id_settings++;
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, 4)) begin
        send_byte(($urandom_range(0, 3) == 0) ? HDR_FIRST : 8'($urandom));
      end
    end else if (r < 70) begin
      send_frame(FR_GOOD, ($urandom_range(0, 99) < 85) ? $urandom_range(0, 10)
                                                         : $urandom_range(11, 31));
    end else if (r < 78) begin
      send_frame(FR_BAD_CRC, $urandom_range(0, 31));
    end else if (r < 82) begin
      send_frame(FR_BAD_ID_HI, $urandom_range(0, 31));
    end else if (r < 86) begin
      send_frame(FR_BAD_ID_LO, $urandom_range(0, 31));
    end else if (r < 90) begin
      send_frame(FR_BAD_HDR2, $urandom_range(0, 31));
    end else if (r < 94) begin
      send_frame(FR_TOO_LONG, $urandom_range(BUFFER_DEPTH_DEF, 255));
    end else begin
      send_frame(FR_CUT, $urandom_range(0, 31));
    end
    if ($urandom_range(0, 19) == 0) quiesce();
  endtask

  initial begin
    logic [7:0] plan_hi [4];
    logic [7:0] plan_lo [4];
    int phase_start;
    plan_hi = '{8'hFF, HDR_FIRST, 8'h00, 8'h00};
    plan_lo = '{8'hFF, HDR_SECOND, 8'h00, 8'h00};
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = 8'h00;
    dev_hi = 8'h00;
    dev_lo = 8'h00;
    bytes_sent = 0;
    frame_bytes = 0;
    frames_sent = 0;
    id_settings = 0;
    burst_left = 0;
    hold_req = 1'b0;
    hold_left = 0;
    stall_pct = 0;
    stall_span = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_ids(8'h00, 8'hFF);
    // hunting: a repeated first header byte falls back, a lone second one is dropped
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_frame(FR_TOO_LONG, BUFFER_DEPTH_DEF);
    send_frame(FR_TOO_LONG, 255);
    send_frame(FR_GOOD, 0);
    send_frame(FR_GOOD, 1);
    send_frame(FR_GOOD, 2);
    send_frame(FR_GOOD, 3);
    send_frame(FR_GOOD, BUFFER_DEPTH_DEF - 1);
    send_frame(FR_BAD_CRC, 5);
    send_frame(FR_BAD_ID_HI, 4);
    send_frame(FR_BAD_ID_LO, 4);
    send_frame(FR_BAD_HDR2, 4);
    quiesce();

    for (int p = 0; p < 4; p++) begin
      if (p == 2) begin
        plan_hi[p] = 8'($urandom);
        plan_lo[p] = 8'($urandom);
      end
      set_ids(plan_hi[p], plan_lo[p]);
      if (p == 0) begin
        write_cfg(REG_UNMAPPED_FIRST, 8'($urandom));
        write_cfg(REG_UNMAPPED_TOP, 8'($urandom));
      end
      phase_start = frame_bytes;
      if (p == 1) begin
        // hold the receiver off while frames keep coming, so replay backs up into input
        hold_req = 1'b1;
        repeat (3) send_frame(FR_GOOD, $urandom_range(8, 20));
      end
      while (frame_bytes - phase_start < PHASE_BYTES) random_item();
      quiesce();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d frames in %0d received bytes over %0d device ID settings,",
             frames_sent, bytes_sent, id_settings);
    $display("with %0d result beats checked against prediction.", beats_checked);
    if (mismatches == 0 && beats_waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (beats_waiting != 0) $display("%0d expected result beats never arrived", beats_waiting);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
